/* rtl/sensor_matrix_lift_place_detector_assert.svh */
// ----------------------------------------------------------------------------
// Lift and place detector assertion macros
// Shared property forms used by the detector's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SENSOR_MATRIX_LIFT_PLACE_DETECTOR_ASSERT_SVH
`define SENSOR_MATRIX_LIFT_PLACE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMLPD_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("smlpd check failed");

// Next-cycle implication, disabled while reset is high.
`define SMLPD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("smlpd check failed");

`endif

/* rtl/smlpd_pkg.sv */
// ----------------------------------------------------------------------------
// Lift and place detector package
// Matrix geometry, field widths, codes and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smlpd_pkg;

   localparam int ROW_COUNT       = 8;
   localparam int COLUMN_COUNT    = 8;
   localparam int SQUARE_COUNT    = ROW_COUNT * COLUMN_COUNT;
   localparam int ROW_INDEX_WIDTH = 3;
   localparam int LEVEL_WIDTH     = 8;
   localparam int SQUARE_WIDTH    = 7;
   localparam int TIMEOUT_WIDTH   = 16;
   localparam int EVENT_DEPTH     = 3;
   localparam int COUNT_WIDTH     = 2;

   localparam logic [SQUARE_WIDTH-1:0]  NO_SQUARE       = SQUARE_WIDTH'(SQUARE_COUNT);
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET   = 16'd5000;
   localparam logic [TIMEOUT_WIDTH-1:0] ELAPSED_MAX     = 16'hFFFF;

   typedef enum logic {
      OP_ROW  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      CSR_LIFT_TIMEOUT = 1'b0,
      CSR_SCAN_ENABLE  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EVENT_LIFTED = 2'd0,
      EVENT_PLACED = 2'd1,
      EVENT_MOVE   = 2'd2
   } event_kind_type;

   typedef struct packed {
      event_kind_type            kind;
      logic [SQUARE_WIDTH-1:0]   origin_square;
      logic [SQUARE_WIDTH-1:0]   dest_square;
   } event_type;

   typedef struct packed {
      logic                        load;
      logic [COUNT_WIDTH-1:0]      count;
      event_type [EVENT_DEPTH-1:0] entries;
   } event_load_type;

   function automatic logic [COLUMN_COUNT-1:0] occupancy(input logic [LEVEL_WIDTH-1:0] levels);
      logic [COLUMN_COUNT-1:0] occ;
      occ = '0;
      for (int c = 0; c < COLUMN_COUNT; c++) begin
         if (c < LEVEL_WIDTH) begin
            occ[c] = ~levels[c % LEVEL_WIDTH];
         end
      end
      return occ;
   endfunction

   function automatic logic [SQUARE_WIDTH-1:0] lowest_square(input logic [SQUARE_COUNT-1:0] bits);
      logic [SQUARE_WIDTH-1:0] found;
      found = NO_SQUARE;
      for (int i = SQUARE_COUNT - 1; i >= 0; i--) begin
         if (bits[i]) begin
            found = SQUARE_WIDTH'(i);
         end
      end
      return found;
   endfunction

endpackage

`default_nettype wire

/* rtl/smlpd_if.sv */
// ----------------------------------------------------------------------------
// Lift and place detector channels
// Valid/ready channels for row samples, events and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smlpd_req_if import smlpd_pkg::*; ;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [ROW_INDEX_WIDTH-1:0] row_index;
   logic [LEVEL_WIDTH-1:0]     column_levels;
   modport source(output valid, op, row_index, column_levels, input ready);
   modport sink(input valid, op, row_index, column_levels, output ready);
endinterface

interface smlpd_rsp_if import smlpd_pkg::*; ;
   logic                    valid;
   logic                    ready;
   event_kind_type          event_kind;
   logic [SQUARE_WIDTH-1:0] origin_square;
   logic [SQUARE_WIDTH-1:0] dest_square;
   logic                    last_event;
   modport source(output valid, event_kind, origin_square, dest_square, last_event, input ready);
   modport sink(input valid, event_kind, origin_square, dest_square, last_event, output ready);
endinterface

interface smlpd_csr_if import smlpd_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic                     index;
   logic [TIMEOUT_WIDTH-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/smlpd_event_queue.sv */
// ----------------------------------------------------------------------------
// Lift and place detector event queue
// Holds the events of a completed scan; sends one word a cycle while ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_matrix_lift_place_detector_assert.svh"

module smlpd_event_queue import smlpd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  event_load_type     load,
   output logic               space,
   smlpd_rsp_if.source        rsp_bus
);

   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   event_type [EVENT_DEPTH-1:0] slots_ff, slots_in;
   logic                        pop;

   assign pop   = rsp_bus.valid && rsp_bus.ready;
   assign space = (count_ff == '0) || ((count_ff == COUNT_WIDTH'(1)) && rsp_bus.ready);

   assign rsp_bus.valid         = count_ff != '0;
   assign rsp_bus.event_kind    = slots_ff[0].kind;
   assign rsp_bus.origin_square = slots_ff[0].origin_square;
   assign rsp_bus.dest_square   = slots_ff[0].dest_square;
   assign rsp_bus.last_event    = count_ff == COUNT_WIDTH'(1);

   always_comb begin
      count_in = count_ff;
      slots_in = slots_ff;
      if (load.load) begin
         count_in = load.count;
         slots_in = load.entries;
      end else if (pop) begin
         count_in = count_ff - COUNT_WIDTH'(1);
         for (int i = 0; i < EVENT_DEPTH - 1; i++) begin
            slots_in[i] = slots_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slots_ff <= slots_in;
   end

   `SMLPD_ASSERT_NOW(a_load_into_free, clock, reset, load.load,
      (count_ff == '0) || ((count_ff == COUNT_WIDTH'(1)) && pop))
   `SMLPD_ASSERT_NOW(a_load_not_empty, clock, reset, load.load, load.count != '0)
   `SMLPD_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !load.load,
      count_ff == $past(count_ff) - COUNT_WIDTH'(1))

endmodule

`default_nettype wire

/* rtl/sensor_matrix_lift_place_detector.sv */
// ----------------------------------------------------------------------------
// Reed-switch matrix lift and place detector
// Builds the occupancy map from row samples and reports lift, place and
// move events at the end of each scan.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  ---------+-----+------------------------------------------------------
//  req_bus  | in  | op, row_index, column_levels
//  rsp_bus  | out | event_kind, origin_square, dest_square, last_event
//  csr_bus  | in  | index (0 lift timeout, 1 scan enable), data
//
// A word is taken into the input register and processed from there.
// Ticks and rows 0 to 6 never wait and are processed back to back.
// A completed scan writes up to three events into the output queue, which
// sends one word per cycle while the receiver is ready.
// The final row waits in the input register until the queue is free.
// Synchronous reset clears the maps, the pending lift and the tick count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sensor_matrix_lift_place_detector import smlpd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   smlpd_req_if.sink   req_bus,
   smlpd_rsp_if.source rsp_bus,
   smlpd_csr_if.sink   csr_bus
);

   logic [TIMEOUT_WIDTH-1:0]   timeout_ff;
   logic                       scan_enable_ff;
   logic [SQUARE_COUNT-1:0]    cur_map_ff, cur_map_in;
   logic [SQUARE_COUNT-1:0]    prev_map_ff, prev_map_in;
   logic [SQUARE_WIDTH-1:0]    pending_ff, pending_in;
   logic [TIMEOUT_WIDTH-1:0]   elapsed_ff, elapsed_in;

   logic                       stage_valid_ff;
   logic                       stage_op_ff;
   logic [ROW_INDEX_WIDTH-1:0] stage_row_ff;
   logic [LEVEL_WIDTH-1:0]     stage_levels_ff;

   logic                       accept;
   logic                       advance;
   logic                       space;
   logic                       is_row;
   logic                       row_ok;
   logic                       final_row;
   logic [COLUMN_COUNT-1:0]    occ;
   logic [SQUARE_COUNT-1:0]    new_map;
   logic [SQUARE_WIDTH-1:0]    lifted;
   logic [SQUARE_WIDTH-1:0]    placed;
   logic [SQUARE_WIDTH-1:0]    pend_lift;
   logic [TIMEOUT_WIDTH-1:0]   elapsed_lift;
   logic [SQUARE_WIDTH-1:0]    pend_move;
   logic                       has_lift;
   logic                       has_place;
   logic                       has_move;
   event_type                  ev_lift;
   event_type                  ev_place;
   event_type                  ev_move;
   event_load_type             load;

   assign csr_bus.ready = 1'b1;

   assign is_row    = stage_op_ff == OP_ROW;
   assign row_ok    = scan_enable_ff && (int'(stage_row_ff) < ROW_COUNT);
   assign final_row = is_row && row_ok && (int'(stage_row_ff) == ROW_COUNT - 1);
   assign advance   = stage_valid_ff && (!final_row || space);
   assign req_bus.ready = !stage_valid_ff || advance;
   assign accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      occ     = occupancy(stage_levels_ff);
      new_map = cur_map_ff;
      for (int r = 0; r < ROW_COUNT; r++) begin
         if (int'(stage_row_ff) == r) begin
            new_map[r*COLUMN_COUNT +: COLUMN_COUNT] = occ;
         end
      end
      lifted    = lowest_square(prev_map_ff & ~new_map);
      placed    = lowest_square(~prev_map_ff & new_map);
      has_lift  = lifted != NO_SQUARE;
      has_place = placed != NO_SQUARE;
      pend_lift    = has_lift ? lifted : pending_ff;
      elapsed_lift = has_lift ? '0 : elapsed_ff;
      has_move  = has_place && (pend_lift != NO_SQUARE) && (pend_lift != placed);
      pend_move = has_move ? NO_SQUARE : pend_lift;

      ev_lift  = '{kind: EVENT_LIFTED, origin_square: lifted, dest_square: NO_SQUARE};
      ev_place = '{kind: EVENT_PLACED, origin_square: NO_SQUARE, dest_square: placed};
      ev_move  = '{kind: EVENT_MOVE, origin_square: pend_lift, dest_square: placed};

      load.entries = '{default: ev_place};
      if (has_lift) begin
         load.entries[0] = ev_lift;
         load.entries[1] = ev_place;
         load.entries[2] = ev_move;
      end else begin
         load.entries[0] = ev_place;
         load.entries[1] = ev_move;
      end
      load.count = COUNT_WIDTH'({1'b0, has_lift}) + COUNT_WIDTH'({1'b0, has_place})
                 + COUNT_WIDTH'({1'b0, has_move});
      load.load  = advance && final_row && (has_lift || has_place);

      cur_map_in  = cur_map_ff;
      prev_map_in = prev_map_ff;
      pending_in  = pending_ff;
      elapsed_in  = elapsed_ff;
      if (advance) begin
         if (!is_row) begin
            if (elapsed_ff != ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + TIMEOUT_WIDTH'(1);
            end
         end else if (row_ok) begin
            cur_map_in = new_map;
            if (final_row) begin
               prev_map_in = new_map;
               elapsed_in  = elapsed_lift;
               pending_in  = pend_move;
               if ((pend_move != NO_SQUARE) && (elapsed_lift > timeout_ff)) begin
                  pending_in = NO_SQUARE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RESET;
         scan_enable_ff <= 1'b1;
         cur_map_ff     <= '0;
         prev_map_ff    <= '0;
         pending_ff     <= NO_SQUARE;
         elapsed_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         cur_map_ff  <= cur_map_in;
         prev_map_ff <= prev_map_in;
         pending_ff  <= pending_in;
         elapsed_ff  <= elapsed_in;
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_LIFT_TIMEOUT: begin
                  timeout_ff <= csr_bus.data;
               end
               CSR_SCAN_ENABLE: begin
                  scan_enable_ff <= csr_bus.data[0];
               end
               default: begin
               end
            endcase
         end
      end
      if (accept) begin
         stage_op_ff     <= req_bus.op;
         stage_row_ff    <= req_bus.row_index;
         stage_levels_ff <= req_bus.column_levels;
      end
   end

   smlpd_event_queue u_event_queue (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .space   (space),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
